/* hw/rtl/source_code_tokenizer_assert.svh */
// Assertion macros shared by the tokenizer checker.
`ifndef SOURCE_CODE_TOKENIZER_ASSERT_SVH
`define SOURCE_CODE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, ignored while in reset.
`define SCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// Next-cycle implication, ignored while in reset.
`define SCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

// Next-cycle implication that also holds across reset.
`define SCT_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

/* hw/rtl/sct_pkg.sv */
package sct_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 256;
  localparam int OFFSET_BITS_DEF   = 32;
  localparam int LINE_BITS_DEF     = 24;
  localparam int COLUMN_BITS_DEF   = 16;

  // Results one request can cause at most
  localparam int MAX_RESULTS = 3;

  // Token kinds
  localparam logic [5:0] K_EOF      = 6'd0;
  localparam logic [5:0] K_IDENT    = 6'd1;
  localparam logic [5:0] K_INT      = 6'd2;
  localparam logic [5:0] K_STRING   = 6'd3;
  localparam logic [5:0] K_SEMI     = 6'd4;
  localparam logic [5:0] K_COMMA    = 6'd5;
  localparam logic [5:0] K_BSLASH   = 6'd6;
  localparam logic [5:0] K_LBRACK   = 6'd7;
  localparam logic [5:0] K_RBRACK   = 6'd8;
  localparam logic [5:0] K_LBRACE   = 6'd9;
  localparam logic [5:0] K_RBRACE   = 6'd10;
  localparam logic [5:0] K_LPAREN   = 6'd11;
  localparam logic [5:0] K_RPAREN   = 6'd12;
  localparam logic [5:0] K_ASSIGN   = 6'd13;
  localparam logic [5:0] K_EQ       = 6'd14;
  localparam logic [5:0] K_FATARROW = 6'd15;
  localparam logic [5:0] K_PLUS     = 6'd16;
  localparam logic [5:0] K_INC      = 6'd17;
  localparam logic [5:0] K_PLUSEQ   = 6'd18;
  localparam logic [5:0] K_MINUS    = 6'd19;
  localparam logic [5:0] K_DEC      = 6'd20;
  localparam logic [5:0] K_MINUSEQ  = 6'd21;
  localparam logic [5:0] K_RARROW   = 6'd22;
  localparam logic [5:0] K_STAR     = 6'd23;
  localparam logic [5:0] K_POW      = 6'd24;
  localparam logic [5:0] K_STAREQ   = 6'd25;
  localparam logic [5:0] K_SLASH    = 6'd26;
  localparam logic [5:0] K_SLASHEQ  = 6'd27;
  localparam logic [5:0] K_HASH     = 6'd28;
  localparam logic [5:0] K_NOT      = 6'd29;
  localparam logic [5:0] K_NE       = 6'd30;
  localparam logic [5:0] K_PCT      = 6'd31;
  localparam logic [5:0] K_PCTPCT   = 6'd32;
  localparam logic [5:0] K_PCTEQ    = 6'd33;
  localparam logic [5:0] K_AMP      = 6'd34;
  localparam logic [5:0] K_ANDAND   = 6'd35;
  localparam logic [5:0] K_ANDNOT   = 6'd36;
  localparam logic [5:0] K_ANDEQ    = 6'd37;
  localparam logic [5:0] K_BAR      = 6'd38;
  localparam logic [5:0] K_OROR     = 6'd39;
  localparam logic [5:0] K_OREQ     = 6'd40;
  localparam logic [5:0] K_CARET    = 6'd41;
  localparam logic [5:0] K_XOREQ    = 6'd42;
  localparam logic [5:0] K_LT       = 6'd43;
  localparam logic [5:0] K_LE       = 6'd44;
  localparam logic [5:0] K_LARROW   = 6'd45;
  localparam logic [5:0] K_SHL      = 6'd46;
  localparam logic [5:0] K_SHLEQ    = 6'd47;
  localparam logic [5:0] K_GT       = 6'd48;
  localparam logic [5:0] K_GE       = 6'd49;
  localparam logic [5:0] K_SHR      = 6'd50;
  localparam logic [5:0] K_SHREQ    = 6'd51;
  localparam logic [5:0] K_TILDE    = 6'd52;
  localparam logic [5:0] K_TILDEEQ  = 6'd53;
  localparam logic [5:0] K_DOT      = 6'd54;
  localparam logic [5:0] K_DOTDOT   = 6'd55;
  localparam logic [5:0] K_ELLIPSIS = 6'd56;
  localparam logic [5:0] K_COLON    = 6'd57;
  localparam logic [5:0] K_DCOLON   = 6'd58;
  localparam logic [5:0] K_QUERY    = 6'd59;
  localparam logic [5:0] K_AT       = 6'd60;
  localparam logic [5:0] K_NONE     = 6'd62;
  localparam logic [5:0] K_ILLEGAL  = 6'd63;

  typedef struct packed {
    logic       action;
    logic [7:0] source_byte;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] start_offset;
    logic [23:0] start_line;
    logic [15:0] start_column;
    logic [8:0]  token_length;
    logic        last_of_run;
  } out_item_t;

  // Results of one request, handed from the scanner to the queue
  typedef struct packed {
    logic [1:0]                       count;
    out_item_t [MAX_RESULTS-1:0]      item;
  } push_t;

  function automatic logic [7:0] bom_byte(input logic [1:0] idx);
    unique case (idx)
      2'd0:    bom_byte = 8'hef;
      2'd1:    bom_byte = 8'hbb;
      default: bom_byte = 8'hbf;
    endcase
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = c == " " || c == 8'h0d || c == 8'h09 || c == 8'h0a;
  endfunction

  // Tokens complete on their own byte
  function automatic logic [5:0] single_kind(input logic [7:0] c);
    unique case (c)
      ";":     single_kind = K_SEMI;
      ",":     single_kind = K_COMMA;
      8'h5c:   single_kind = K_BSLASH;
      "[":     single_kind = K_LBRACK;
      "]":     single_kind = K_RBRACK;
      "{":     single_kind = K_LBRACE;
      "}":     single_kind = K_RBRACE;
      "(":     single_kind = K_LPAREN;
      ")":     single_kind = K_RPAREN;
      "#":     single_kind = K_HASH;
      "?":     single_kind = K_QUERY;
      "@":     single_kind = K_AT;
      default: single_kind = K_NONE;
    endcase
  endfunction

  // First byte of an operator that may grow
  function automatic logic [5:0] op_start(input logic [7:0] c);
    unique case (c)
      "=":     op_start = K_ASSIGN;
      "+":     op_start = K_PLUS;
      "-":     op_start = K_MINUS;
      "*":     op_start = K_STAR;
      "/":     op_start = K_SLASH;
      "!":     op_start = K_NOT;
      "%":     op_start = K_PCT;
      "&":     op_start = K_AMP;
      "|":     op_start = K_BAR;
      "^":     op_start = K_CARET;
      "<":     op_start = K_LT;
      ">":     op_start = K_GT;
      "~":     op_start = K_TILDE;
      ".":     op_start = K_DOT;
      ":":     op_start = K_COLON;
      default: op_start = K_NONE;
    endcase
  endfunction

  // Longer operator formed by appending c, or K_NONE
  function automatic logic [5:0] extend(input logic [5:0] k, input logic [7:0] c);
    extend = K_NONE;
    unique case (k)
      K_ASSIGN: extend = c == "=" ? K_EQ : c == ">" ? K_FATARROW : K_NONE;
      K_PLUS:   extend = c == "+" ? K_INC : c == "=" ? K_PLUSEQ : K_NONE;
      K_MINUS:  extend = c == "-" ? K_DEC : c == "=" ? K_MINUSEQ :
                         c == ">" ? K_RARROW : K_NONE;
      K_STAR:   extend = c == "*" ? K_POW : c == "=" ? K_STAREQ : K_NONE;
      K_SLASH:  extend = c == "=" ? K_SLASHEQ : K_NONE;
      K_NOT:    extend = c == "=" ? K_NE : K_NONE;
      K_PCT:    extend = c == "%" ? K_PCTPCT : c == "=" ? K_PCTEQ : K_NONE;
      K_AMP:    extend = c == "&" ? K_ANDAND : c == "^" ? K_ANDNOT :
                         c == "=" ? K_ANDEQ : K_NONE;
      K_BAR:    extend = c == "|" ? K_OROR : c == "=" ? K_OREQ : K_NONE;
      K_CARET:  extend = c == "=" ? K_XOREQ : K_NONE;
      K_LT:     extend = c == "=" ? K_LE : c == "-" ? K_LARROW :
                         c == "<" ? K_SHL : K_NONE;
      K_SHL:    extend = c == "=" ? K_SHLEQ : K_NONE;
      K_GT:     extend = c == "=" ? K_GE : c == ">" ? K_SHR : K_NONE;
      K_SHR:    extend = c == "=" ? K_SHREQ : K_NONE;
      K_TILDE:  extend = c == "=" ? K_TILDEEQ : K_NONE;
      K_DOT:    extend = c == "." ? K_DOTDOT : K_NONE;
      K_DOTDOT: extend = c == "." ? K_ELLIPSIS : K_NONE;
      K_COLON:  extend = c == ":" ? K_DCOLON : K_NONE;
      default:  extend = K_NONE;
    endcase
  endfunction

  function automatic logic can_grow(input logic [5:0] k);
    can_grow = k == K_SHL || k == K_SHR || k == K_DOTDOT;
  endfunction

endpackage

/* hw/rtl/sct_scanner.sv */
module sct_scanner #(
  parameter int MAX_TOKEN_LEN = sct_pkg::MAX_TOKEN_LEN_DEF,
  parameter int OFFSET_BITS   = sct_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS     = sct_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS   = sct_pkg::COLUMN_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  sct_pkg::in_item_t in_item,
  output sct_pkg::push_t    push
);

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam int NCAND = 5;

  // Scan modes
  localparam logic [3:0] M_BOM   = 4'd0;
  localparam logic [3:0] M_IDLE  = 4'd1;
  localparam logic [3:0] M_IDENT = 4'd2;
  localparam logic [3:0] M_NUM   = 4'd3;
  localparam logic [3:0] M_STR   = 4'd4;
  localparam logic [3:0] M_ESC   = 4'd5;
  localparam logic [3:0] M_LINEC = 4'd6;
  localparam logic [3:0] M_BLOCK = 4'd7;
  localparam logic [3:0] M_BSTAR = 4'd8;
  localparam logic [3:0] M_OP    = 4'd9;

  logic [3:0]             mode, mode_next;
  logic [5:0]             pend_op, pend_op_next;
  logic [1:0]             bom_cnt, bom_cnt_next;
  logic [OFFSET_BITS-1:0] offset, offset_next;
  logic [LINE_BITS-1:0]   line, line_next;
  logic [COLUMN_BITS-1:0] col, col_next;
  logic [OFFSET_BITS-1:0] tok_off, tok_off_next;
  logic [LINE_BITS-1:0]   tok_line, tok_line_next;
  logic [COLUMN_BITS-1:0] tok_col, tok_col_next;
  logic [LEN_W-1:0]       tok_len, tok_len_next;

  sct_pkg::out_item_t cand [NCAND];
  logic [NCAND-1:0]   cand_v;

  function automatic sct_pkg::out_item_t mk(input logic [5:0] kind,
                                            input logic [OFFSET_BITS-1:0] o,
                                            input logic [LINE_BITS-1:0] l,
                                            input logic [COLUMN_BITS-1:0] cl,
                                            input logic [LEN_W-1:0] n);
    sct_pkg::out_item_t r;
    r.token_kind   = kind;
    r.start_offset = 32'(o);
    r.start_line   = 24'(l);
    r.start_column = 16'(cl);
    r.token_length = 9'(n);
    r.last_of_run  = 1'b0;
    mk = r;
  endfunction

  // One request: mode decision, candidate results and next counters
  always_comb begin
    logic [7:0]       c;
    logic             do_idle;
    logic             pend_v;
    logic [5:0]       pend_kind;
    logic [LEN_W-1:0] pend_len;
    logic [LEN_W-1:0] len_grown;
    logic [5:0]       single_k;
    logic [5:0]       op_k;
    logic [5:0]       ext_k;

    c         = in_item.source_byte;
    do_idle   = 1'b0;
    pend_v    = 1'b0;
    pend_kind = sct_pkg::K_NONE;
    pend_len  = tok_len;
    len_grown = (tok_len < LEN_W'(MAX_TOKEN_LEN)) ? tok_len + LEN_W'(1) : tok_len;
    single_k  = sct_pkg::single_kind(c);
    op_k      = sct_pkg::op_start(c);
    ext_k     = sct_pkg::extend(pend_op, c);

    mode_next     = mode;
    pend_op_next  = pend_op;
    bom_cnt_next  = bom_cnt;
    offset_next   = offset;
    line_next     = line;
    col_next      = col;
    tok_off_next  = tok_off;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    tok_len_next  = tok_len;
    cand_v        = '0;
    for (int i = 0; i < NCAND; i++) cand[i] = '0;

    // Replays of a partly matched byte-order mark
    cand[0] = mk(sct_pkg::K_ILLEGAL, '0, LINE_BITS'(1), COLUMN_BITS'(1), LEN_W'(1));
    cand[1] = mk(sct_pkg::K_ILLEGAL, OFFSET_BITS'(1), LINE_BITS'(1), COLUMN_BITS'(2),
                 LEN_W'(1));

    if (in_item.action) begin
      // End of text: flush, end-of-file, back to reset state
      cand_v[0] = (mode == M_BOM) && (bom_cnt >= 2'd1);
      cand_v[1] = (mode == M_BOM) && (bom_cnt >= 2'd2);
      unique case (mode)
        M_IDENT: begin pend_v = 1'b1; pend_kind = sct_pkg::K_IDENT; end
        M_NUM:   begin pend_v = 1'b1; pend_kind = sct_pkg::K_INT; end
        M_STR, M_ESC: begin pend_v = 1'b1; pend_kind = sct_pkg::K_ILLEGAL; end
        M_OP:    begin pend_v = 1'b1; pend_kind = pend_op; end
        default: pend_v = 1'b0;
      endcase
      cand[4]       = mk(sct_pkg::K_EOF, offset, line, col, '0);
      cand_v[4]     = 1'b1;
      mode_next     = M_BOM;
      pend_op_next  = sct_pkg::K_EOF;
      bom_cnt_next  = '0;
      offset_next   = '0;
      line_next     = LINE_BITS'(1);
      col_next      = COLUMN_BITS'(1);
      tok_off_next  = '0;
      tok_line_next = LINE_BITS'(1);
      tok_col_next  = COLUMN_BITS'(1);
      tok_len_next  = '0;
    end else begin
      if (mode == M_BOM) begin
        if (c == sct_pkg::bom_byte(bom_cnt)) begin
          if (bom_cnt == 2'd2) begin
            bom_cnt_next = '0;
            mode_next    = M_IDLE;
          end else begin
            bom_cnt_next = bom_cnt + 2'd1;
          end
        end else begin
          cand_v[0]    = bom_cnt >= 2'd1;
          cand_v[1]    = bom_cnt >= 2'd2;
          bom_cnt_next = '0;
          do_idle      = 1'b1;
        end
      end else begin
        unique case (mode)
          M_IDENT: begin
            if (sct_pkg::is_alpha(c) || sct_pkg::is_digit(c)) begin
              tok_len_next = len_grown;
            end else begin
              pend_v = 1'b1; pend_kind = sct_pkg::K_IDENT; do_idle = 1'b1;
            end
          end
          M_NUM: begin
            if (sct_pkg::is_digit(c)) begin
              tok_len_next = len_grown;
            end else begin
              pend_v = 1'b1; pend_kind = sct_pkg::K_INT; do_idle = 1'b1;
            end
          end
          M_STR: begin
            if (c == "\"") begin
              pend_v = 1'b1; pend_kind = sct_pkg::K_STRING; mode_next = M_IDLE;
            end else begin
              tok_len_next = len_grown;
              if (c == 8'h5c) mode_next = M_ESC;
            end
          end
          M_ESC: begin
            tok_len_next = len_grown;
            mode_next    = M_STR;
          end
          M_LINEC: begin
            if (c == 8'h0a) mode_next = M_IDLE;
          end
          M_BLOCK: begin
            if (c == "*") mode_next = M_BSTAR;
          end
          M_BSTAR: begin
            if (c == "/") mode_next = M_IDLE;
            else if (c != "*") mode_next = M_BLOCK;
          end
          M_OP: begin
            if (pend_op == sct_pkg::K_SLASH && c == "/") begin
              mode_next = M_LINEC;
            end else if (pend_op == sct_pkg::K_SLASH && c == "*") begin
              mode_next = M_BLOCK;
            end else if (ext_k != sct_pkg::K_NONE) begin
              pend_op_next = ext_k;
              tok_len_next = len_grown;
              if (!sct_pkg::can_grow(ext_k)) begin
                pend_v = 1'b1; pend_kind = ext_k; pend_len = len_grown;
                mode_next = M_IDLE;
              end
            end else begin
              pend_v = 1'b1; pend_kind = pend_op; do_idle = 1'b1;
            end
          end
          default: do_idle = 1'b1;
        endcase
      end

      // Byte seen with no token open
      if (do_idle) begin
        mode_next = M_IDLE;
        cand[3]   = mk(sct_pkg::K_ILLEGAL, offset, line, col, LEN_W'(1));
        if (sct_pkg::is_space(c)) begin
          mode_next = M_IDLE;
        end else if (sct_pkg::is_alpha(c) || (c >= "1" && c <= "9") ||
                     c == "\"" || (single_k == sct_pkg::K_NONE &&
                                   op_k != sct_pkg::K_NONE)) begin
          tok_off_next  = offset;
          tok_line_next = line;
          tok_col_next  = col;
          tok_len_next  = (c == "\"") ? '0 : LEN_W'(1);
          if (sct_pkg::is_alpha(c)) mode_next = M_IDENT;
          else if (sct_pkg::is_digit(c)) mode_next = M_NUM;
          else if (c == "\"") mode_next = M_STR;
          else begin
            mode_next    = M_OP;
            pend_op_next = op_k;
          end
        end else if (single_k != sct_pkg::K_NONE) begin
          cand[3].token_kind = single_k;
          cand_v[3]          = 1'b1;
        end else begin
          cand_v[3] = 1'b1;
        end
      end

      // Position counters, saturating
      if (offset != '1) offset_next = offset + OFFSET_BITS'(1);
      if (c == 8'h0a) begin
        if (line != '1) line_next = line + LINE_BITS'(1);
        col_next = COLUMN_BITS'(1);
      end else if (col != '1) begin
        col_next = col + COLUMN_BITS'(1);
      end
    end

    cand[2]   = mk(pend_kind, tok_off, tok_line, tok_col, pend_len);
    cand_v[2] = pend_v;
  end

  // Pack valid candidates in order and flag the last one
  always_comb begin
    logic [1:0] n;
    n    = '0;
    push = '0;
    for (int j = 0; j < NCAND; j++) begin
      if (cand_v[j] && n != 2'(sct_pkg::MAX_RESULTS)) begin
        push.item[n] = cand[j];
        n            = n + 2'd1;
      end
    end
    for (int i = 0; i < sct_pkg::MAX_RESULTS; i++) begin
      push.item[i].last_of_run = (n != 2'd0) && (2'(i) == n - 2'd1);
    end
    push.count = accept ? n : 2'd0;
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_BOM;
      pend_op  <= sct_pkg::K_EOF;
      bom_cnt  <= '0;
      offset   <= '0;
      line     <= LINE_BITS'(1);
      col      <= COLUMN_BITS'(1);
      tok_off  <= '0;
      tok_line <= LINE_BITS'(1);
      tok_col  <= COLUMN_BITS'(1);
      tok_len  <= '0;
    end else if (accept) begin
      mode     <= mode_next;
      pend_op  <= pend_op_next;
      bom_cnt  <= bom_cnt_next;
      offset   <= offset_next;
      line     <= line_next;
      col      <= col_next;
      tok_off  <= tok_off_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
      tok_len  <= tok_len_next;
    end
  end

endmodule

/* hw/rtl/sct_queue.sv */
module sct_queue (
  input  logic               clk,
  input  logic               rst,
  input  sct_pkg::push_t     push,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output sct_pkg::out_item_t out_item
);

  localparam int DEPTH = 4;

  sct_pkg::out_item_t mem [DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign out_valid = count != 3'd0;
  assign out_item  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // Room for a full run of results is guaranteed whenever count <= 1
  assign full      = count > 3'd1;

  // Result storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < sct_pkg::MAX_RESULTS; i++) begin
      if (2'(i) < push.count) mem[wr_ptr + 2'(i)] <= push.item[i];
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push.count) - 3'(pop);
    end
  end

endmodule

/* hw/rtl/source_code_tokenizer.sv */
// Source code tokenizer.
// Input channel (in_valid, in_stall, in_item): one request per byte of
// source text, or an end marker (action = 1) that flushes any open token
// and emits end-of-file.
// Output channel (out_valid, out_stall, out_item): tokens with kind, start
// offset, line, column and length; last_of_run marks the final token that a
// request caused. A request causes zero to three tokens.
// Throughput: one request per cycle while in_stall is low; the tokens a
// request ends are written into the queue as it is taken. The scanner
// decides everything for a byte combinationally; its results enter a
// four-entry queue that drains one token per cycle unless out_stall is
// high, so in_stall rises while more than one token waits: only when
// requests produce tokens faster than one a cycle or the receiver stalls.
// Reset (rst, synchronous) empties the queue and returns the scanner to the
// start of a text, expecting an optional byte-order mark; the scanner also
// returns there after every end marker, while the queue keeps its tokens.
// While out_stall is high the presented token holds and requests are taken
// until the queue has no room for a full run of results.
module source_code_tokenizer #(
  parameter int MAX_TOKEN_LEN = sct_pkg::MAX_TOKEN_LEN_DEF,
  parameter int OFFSET_BITS   = sct_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS     = sct_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS   = sct_pkg::COLUMN_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sct_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sct_pkg::out_item_t out_item
);

  logic           accept;
  logic           full;
  sct_pkg::push_t push;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  sct_scanner #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .OFFSET_BITS  (OFFSET_BITS),
    .LINE_BITS    (LINE_BITS),
    .COLUMN_BITS  (COLUMN_BITS)
  ) u_scanner (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .in_item(in_item),
    .push   (push)
  );

  sct_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

/* hw/rtl/sct_checker.sv */
`include "source_code_tokenizer_assert.svh"

module sct_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input sct_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input sct_pkg::out_item_t out_item
);

  // A stalled token holds
  `SCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

  // An end marker always yields a token on the next cycle
  `SCT_ASSERT_NEXT(a_end_gives_token, in_valid && !in_stall && in_item.action, out_valid)

  // End-of-file closes its run
  `SCT_ASSERT_NOW(a_eof_last, out_valid && out_item.token_kind == sct_pkg::K_EOF,
                  out_item.last_of_run)

  // Leaving reset: nothing pending, ready for requests
  `SCT_ASSERT_ALWAYS(a_reset_empty, rst, !out_valid && !in_stall)

endmodule

bind source_code_tokenizer sct_checker u_sct_checker (.*);
